// ===== hdl/keyboard_scancode_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_core_macros
// Assertion macros shared by the scancode decoder RTL.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scancode decoder assertion failed");

// next-cycle implication, checked out of reset
`define KSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scancode decoder assertion failed");

`endif

// ===== hdl/kbd_scd_pkg.sv =====
// ----------------------------------------------------------------------------
// kbd_scd_pkg
// Types and constants for the keyboard scancode decoder.
// ----------------------------------------------------------------------------
package kbd_scd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;

    localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_RESYNC   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_RST_ID   = 8'h04;
    localparam logic [BYTE_W-1:0] BYTE_ALL_UP   = 8'h7F;
    localparam logic [BYTE_W-1:0] BYTE_MAKE_MAX = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_IDLE     = 8'hFE;
    localparam logic [BYTE_W-1:0] KEY_MASK      = 8'h7F;

    localparam logic [BYTE_W-1:0] UNPLUG_THR_RST = 8'd16;

    typedef enum logic [1:0] {
        PH_UNINIT     = 2'd0,
        PH_AFTER_FF   = 2'd1,
        PH_AFTER_FF04 = 2'd2,
        PH_NORMAL     = 2'd3
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 3'd0,
        EV_UNKNOWN = 3'd1,
        EV_RESET   = 3'd2,
        EV_MAKE    = 3'd3,
        EV_BREAK   = 3'd4,
        EV_ALLUP   = 3'd5
    } event_kind_t;

endpackage

// ===== hdl/kbd_scd_byte_if.sv =====
// ----------------------------------------------------------------------------
// kbd_scd_byte_if
// Received keyboard byte channel.
// ----------------------------------------------------------------------------
interface kbd_scd_byte_if;
    logic                           valid;
    logic                           ready;
    logic [kbd_scd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/kbd_scd_event_if.sv =====
// ----------------------------------------------------------------------------
// kbd_scd_event_if
// Decoded key event channel.
// ----------------------------------------------------------------------------
interface kbd_scd_event_if;
    logic                           valid;
    logic                           ready;
    logic [kbd_scd_pkg::KIND_W-1:0] event_kind;
    logic [kbd_scd_pkg::BYTE_W-1:0] key_code;

    modport source (output valid, output event_kind, output key_code, input ready);
    modport sink   (input valid, input event_kind, input key_code, output ready);
endinterface

// ===== hdl/kbd_scd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kbd_scd_cfg_if
// Configuration write channel for the unplug threshold.
// ----------------------------------------------------------------------------
interface kbd_scd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kbd_scd_pkg::BYTE_W-1:0] unplug_threshold;

    modport source (output valid, output unplug_threshold, input ready);
    modport sink   (input valid, input unplug_threshold, output ready);
endinterface

// ===== hdl/keyboard_scancode_decoder_core.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_decoder_core
// Make/break scancode decoder for a serial keyboard byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one received keyboard byte per word (valid/ready).
//   evt : one event word per byte: event_kind and key_code.
//   cfg : write-only unplug threshold, always ready; write it while idle.
// Path: a byte accepted on rx passes the input register, then the result
//   register, on its way to evt. Throughput is one byte per cycle while evt
//   is ready; the link phase and zero-byte count update in the single decode
//   step between the two registers, which sets that figure.
// Stall: when evt is held off, the result register keeps its word and the
//   input register takes one more byte; rx ready then drops until evt
//   drains. rx ready follows evt ready combinationally.
// Reset: rst_n (async, active low) empties both registers, sets the link
//   to uninitialised, clears the zero-byte count and loads the threshold
//   with 16.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_decoder_core_macros.svh"

module keyboard_scancode_decoder_core (
    input  logic                   clk,
    input  logic                   rst_n,
    kbd_scd_byte_if.sink           rx,
    kbd_scd_event_if.source        evt,
    kbd_scd_cfg_if.sink            cfg
);

    logic                           in_valid_reg;
    logic [kbd_scd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                           out_valid_reg;
    kbd_scd_pkg::event_kind_t       kind_reg;
    kbd_scd_pkg::event_kind_t       kind_next;
    logic [kbd_scd_pkg::BYTE_W-1:0] code_reg;
    logic [kbd_scd_pkg::BYTE_W-1:0] code_next;

    kbd_scd_pkg::phase_t            phase_reg;
    kbd_scd_pkg::phase_t            phase_next;
    logic [kbd_scd_pkg::BYTE_W-1:0] zero_run_reg;
    logic [kbd_scd_pkg::BYTE_W-1:0] zero_run_next;
    logic [kbd_scd_pkg::BYTE_W-1:0] thr_reg;

    logic                           advance;
    logic                           is_zero;

    assign advance   = in_valid_reg && (!out_valid_reg || evt.ready);
    assign rx.ready  = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign is_zero   = (in_byte_reg == kbd_scd_pkg::BYTE_ZERO);

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = kind_reg;
    assign evt.key_code   = code_reg;

    // next link phase and zero count
    always_comb
    begin
        phase_next    = phase_reg;
        zero_run_next = zero_run_reg;
        if (is_zero)
        begin
            // zero_run_reg < thr_reg <= 255, so the increment cannot wrap
            if (zero_run_reg < thr_reg)
            begin
                zero_run_next = zero_run_reg + 8'd1;
            end
            if (zero_run_next >= thr_reg)
            begin
                phase_next = kbd_scd_pkg::PH_UNINIT;
            end
        end
        else
        begin
            zero_run_next = '0;
            unique case (phase_reg)
                kbd_scd_pkg::PH_UNINIT:
                begin
                    if (in_byte_reg == kbd_scd_pkg::BYTE_RESYNC)
                    begin
                        phase_next = kbd_scd_pkg::PH_AFTER_FF;
                    end
                end
                kbd_scd_pkg::PH_AFTER_FF:
                begin
                    if (in_byte_reg == kbd_scd_pkg::BYTE_RST_ID)
                    begin
                        phase_next = kbd_scd_pkg::PH_AFTER_FF04;
                    end
                    else if (in_byte_reg != kbd_scd_pkg::BYTE_RESYNC)
                    begin
                        phase_next = kbd_scd_pkg::PH_UNINIT;
                    end
                end
                kbd_scd_pkg::PH_AFTER_FF04:
                begin
                    if (in_byte_reg <= kbd_scd_pkg::BYTE_ALL_UP)
                    begin
                        phase_next = kbd_scd_pkg::PH_NORMAL;
                    end
                    else
                    begin
                        phase_next = kbd_scd_pkg::PH_UNINIT;
                    end
                end
                kbd_scd_pkg::PH_NORMAL:
                begin
                    if (in_byte_reg == kbd_scd_pkg::BYTE_RESYNC)
                    begin
                        phase_next = kbd_scd_pkg::PH_AFTER_FF;
                    end
                end
                default:
                begin
                    phase_next = kbd_scd_pkg::PH_UNINIT;
                end
            endcase
        end
    end

    // event decode
    always_comb
    begin
        kind_next = kbd_scd_pkg::EV_NONE;
        code_next = '0;
        if (!is_zero)
        begin
            unique case (phase_reg)
                kbd_scd_pkg::PH_UNINIT:
                begin
                    kind_next = kbd_scd_pkg::EV_NONE;
                end
                kbd_scd_pkg::PH_AFTER_FF:
                begin
                    if ((in_byte_reg != kbd_scd_pkg::BYTE_RST_ID) &&
                        (in_byte_reg != kbd_scd_pkg::BYTE_RESYNC))
                    begin
                        kind_next = kbd_scd_pkg::EV_UNKNOWN;
                        code_next = in_byte_reg;
                    end
                end
                kbd_scd_pkg::PH_AFTER_FF04:
                begin
                    if (in_byte_reg <= kbd_scd_pkg::BYTE_ALL_UP)
                    begin
                        kind_next = kbd_scd_pkg::EV_RESET;
                    end
                    else
                    begin
                        kind_next = kbd_scd_pkg::EV_UNKNOWN;
                        code_next = in_byte_reg;
                    end
                end
                kbd_scd_pkg::PH_NORMAL:
                begin
                    if (in_byte_reg <= kbd_scd_pkg::BYTE_MAKE_MAX)
                    begin
                        kind_next = kbd_scd_pkg::EV_MAKE;
                        code_next = in_byte_reg;
                    end
                    else if (in_byte_reg == kbd_scd_pkg::BYTE_ALL_UP)
                    begin
                        kind_next = kbd_scd_pkg::EV_ALLUP;
                    end
                    else if (in_byte_reg < kbd_scd_pkg::BYTE_IDLE)
                    begin
                        kind_next = kbd_scd_pkg::EV_BREAK;
                        code_next = in_byte_reg & kbd_scd_pkg::KEY_MASK;
                    end
                end
                default:
                begin
                    kind_next = kbd_scd_pkg::EV_NONE;
                end
            endcase
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= kbd_scd_pkg::PH_UNINIT;
            zero_run_reg  <= '0;
            thr_reg       <= kbd_scd_pkg::UNPLUG_THR_RST;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                zero_run_reg  <= zero_run_next;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                thr_reg <= cfg.unplug_threshold;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            kind_reg <= kind_next;
            code_reg <= code_next;
        end
    end

    `KSD_ASSERT_NXT(a_zero_gives_none, clk, rst_n, advance && is_zero,
        out_valid_reg && (kind_reg == kbd_scd_pkg::EV_NONE) && (code_reg == '0))
    `KSD_ASSERT_NXT(a_nonzero_clears_run, clk, rst_n, advance && !is_zero,
        zero_run_reg == '0)
    `KSD_ASSERT_NXT(a_unplug_uninit, clk, rst_n,
        advance && is_zero && (zero_run_reg >= thr_reg),
        phase_reg == kbd_scd_pkg::PH_UNINIT)
    `KSD_ASSERT_IMP(a_make_code_range, clk, rst_n,
        out_valid_reg && (kind_reg == kbd_scd_pkg::EV_MAKE),
        (code_reg != '0) && !code_reg[kbd_scd_pkg::BYTE_W-1])
    `KSD_ASSERT_IMP(a_codeless_events, clk, rst_n,
        out_valid_reg && ((kind_reg == kbd_scd_pkg::EV_NONE) ||
        (kind_reg == kbd_scd_pkg::EV_RESET) || (kind_reg == kbd_scd_pkg::EV_ALLUP)),
        code_reg == '0)

endmodule
